@@ rtl/core/interlaced_two_bit_rle_subtitle_decoder_defines.svh @@
// assertion macros for the subtitle decoder rtl, used by the decode sequencer
// expects clk and arst_n in the module that uses them
`ifndef INTERLACED_TWO_BIT_RLE_SUBTITLE_DECODER_DEFINES_SVH
`define INTERLACED_TWO_BIT_RLE_SUBTITLE_DECODER_DEFINES_SVH

// same-cycle implication, idle during reset
`define ISRD_ASSERT_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, idle during reset
`define ISRD_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/isrd_pkg.sv @@
// shared types, constants and helpers of the subtitle rle decoder
// no dependencies
package isrd_pkg;

	localparam int DIM_BITS        = 10;
	localparam int OFFSET_BITS     = 16;
	localparam int CFG_DATA_BITS   = (OFFSET_BITS > DIM_BITS) ? OFFSET_BITS : DIM_BITS;
	localparam int CFG_INDEX_BITS  = 2;
	localparam int BYTE_BITS       = 8;
	localparam int FIELD_BITS      = 2;
	localparam int FIELDS_PER_BYTE = 4;
	localparam int FIELD_IDX_BITS  = $clog2(FIELDS_PER_BYTE);
	localparam int FLD_BITS        = $clog2(FIELDS_PER_BYTE + 1);
	localparam int QUEUE_PTR_BITS  = 2;
	localparam int QUEUE_DEPTH     = 1 << QUEUE_PTR_BITS;

	localparam logic [FLD_BITS-1:0] LAST_FIELD = FLD_BITS'(FIELDS_PER_BYTE - 1);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT,
		REG_ODD_FIELD_START,
		REG_DATA_LENGTH
	} cfg_reg_t;

	typedef logic [FIELD_BITS-1:0] field_t;

	typedef struct packed {
		logic [DIM_BITS-1:0]    image_width;
		logic [DIM_BITS-1:0]    image_height;
		logic [OFFSET_BITS-1:0] odd_field_start;
		logic [OFFSET_BITS-1:0] data_length;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] data_byte;
		logic                 first_byte;
	} in_item_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] pixel_index;
		logic [DIM_BITS-1:0]   pixel_row;
		logic [DIM_BITS-1:0]   pixel_column;
		logic                  end_of_image;
		logic                  decode_error;
		logic                  last_of_item;
	} out_item_t;

	// byte split into its fields, high pair at index 0
	typedef struct packed {
		logic [FIELDS_PER_BYTE-1:0][FIELD_BITS-1:0] fields;
		logic                                       restart;
	} q_entry_t;

	function automatic field_t field_of(logic [BYTE_BITS-1:0] b,
			logic [FIELD_IDX_BITS-1:0] k);
		logic [BYTE_BITS-1:0] sh;
		sh = b >> (FIELD_BITS * (FIELDS_PER_BYTE - 1 - int'(k)));
		return sh[FIELD_BITS-1:0];
	endfunction

endpackage

@@ rtl/core/interlaced_two_bit_rle_subtitle_decoder.sv @@
// top level of the interlaced two-bit rle subtitle decoder: config registers,
// byte queue front end and decode sequencer; depends on isrd_pkg, isrd_front, isrd_decode
//
//   channel | handshake                 | payload
//   --------+---------------------------+----------------------------------
//   in      | in_valid / in_stall       | in_item  (data byte, first flag)
//   out     | out_valid / out_stall     | out_item (one pixel or error)
//   cfg     | cfg_we                    | cfg_index, cfg_data
//
// at most one result per cycle while out_stall is low; the sequencer finishes a byte before taking the next
// a byte ending on a zero field takes the run count of that field from the next byte
// that rate is set by the single decode step per cycle of the decode sequencer when it is not stalled
// reset clears the config and leaves the decoder idle until a first byte arrives
// out_stall freezes a waiting result and the sequencer; the four-byte queue takes input until full
module interlaced_two_bit_rle_subtitle_decoder (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  isrd_pkg::in_item_t                     in_item,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output isrd_pkg::out_item_t                    out_item,
	input  logic                                   cfg_we,
	input  logic [isrd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [isrd_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
	import isrd_pkg::*;

	cfg_t     cfg_q;
	logic     q_valid, q_take;
	q_entry_t q_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:     cfg_q.image_width     <= cfg_data[DIM_BITS-1:0];
				REG_IMAGE_HEIGHT:    cfg_q.image_height    <= cfg_data[DIM_BITS-1:0];
				REG_ODD_FIELD_START: cfg_q.odd_field_start <= cfg_data[OFFSET_BITS-1:0];
				REG_DATA_LENGTH:     cfg_q.data_length     <= cfg_data[OFFSET_BITS-1:0];
				default: ;
			endcase
		end
	end

	isrd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_take   (q_take),
		.q_entry  (q_entry)
	);

	isrd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_take    (q_take),
		.q_entry   (q_entry),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

@@ rtl/core/isrd_front.sv @@
// input side: takes bytes, splits them into fields and queues them
// depends on isrd_pkg
module isrd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  isrd_pkg::in_item_t in_item,
	output logic               q_valid,
	input  logic               q_take,
	output isrd_pkg::q_entry_t q_entry
);
	import isrd_pkg::*;

	q_entry_t                  slot_q [QUEUE_DEPTH];
	q_entry_t                  entry_c;
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_PTR_BITS:0]   count_q;
	logic                      push, pop;

	always_comb begin
		for (int k = 0; k < FIELDS_PER_BYTE; k++) begin
			entry_c.fields[k] = field_of(in_item.data_byte, FIELD_IDX_BITS'(k));
		end
		entry_c.restart = in_item.first_byte;
	end

	assign in_stall = (count_q == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_entry  = slot_q[rd_ptr_q];
	assign push     = in_valid && !in_stall;
	assign pop      = q_valid && q_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= entry_c;
	end

endmodule

@@ rtl/core/isrd_decode.sv @@
// decode sequencer: one rle step per cycle unless stalled, at most one pixel per step, output register
// depends on isrd_pkg and the assertion macro header
`include "interlaced_two_bit_rle_subtitle_decoder_defines.svh"

module isrd_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  isrd_pkg::cfg_t      cfg,
	input  logic                q_valid,
	output logic                q_take,
	input  isrd_pkg::q_entry_t  q_entry,
	output logic                out_valid,
	input  logic                out_stall,
	output isrd_pkg::out_item_t out_item
);
	import isrd_pkg::*;

	// per-byte sequencer state
	logic                                       busy_q, perr_q, live_q;
	logic [FLD_BITS-1:0]                        fld_q;
	logic [FIELDS_PER_BYTE-1:0][FIELD_BITS-1:0] fields_q;
	// decoding state kept across bytes
	logic [OFFSET_BITS-1:0]                     pos_q;
	logic [DIM_BITS-1:0]                        row_q, col_q;
	logic                                       odd_q, aw_q, fin_q;
	logic [FIELD_BITS-1:0]                      zp_q;
	// output register
	logic                                       out_valid_q;
	out_item_t                                  out_q;

	logic                                       ready_adv, start, go, run;
	logic [FIELDS_PER_BYTE-1:0][FIELD_BITS-1:0] fields_c;
	logic [FLD_BITS-1:0]                        fld_c, fld_a, fld_n;
	logic                                       live_c, perr_c, live_n, perr_n;
	logic [OFFSET_BITS-1:0]                     pos_c, pos_n;
	logic [DIM_BITS-1:0]                        row_c, col_c, row_n, col_n;
	logic                                       odd_c, aw_c, fin_c, odd_n, aw_n, fin_n;
	logic [FIELD_BITS-1:0]                      zp_c, zp_n, f_a, f_b, color;
	logic [OFFSET_BITS:0]                       pos_inc;
	logic [DIM_BITS:0]                          col_inc, nr;
	logic                                       adv_ok, row_end, eoi_c;
	logic                                       pix, is_err, done, silent, emit, busy_n;
	out_item_t                                  out_n;

	always_comb begin
		ready_adv = !out_valid_q || !out_stall;
		start     = !busy_q && q_valid;
		go        = ready_adv && (busy_q || q_valid);
		q_take    = !busy_q && ready_adv;

		fields_c = busy_q ? fields_q : q_entry.fields;
		fld_c    = busy_q ? fld_q : '0;
		live_c   = busy_q ? live_q : 1'b1;
		perr_c   = busy_q && perr_q;
		pos_c    = pos_q;
		row_c    = row_q;
		col_c    = col_q;
		odd_c    = odd_q;
		zp_c     = zp_q;
		aw_c     = aw_q;
		fin_c    = fin_q;
		run      = busy_q;

		// classify the byte at the head of the queue
		if (start) begin
			if (q_entry.restart) begin
				pos_c = '0;
				row_c = '0;
				col_c = '0;
				odd_c = 1'b0;
				zp_c  = '0;
				aw_c  = 1'b0;
				run   = (cfg.image_width != '0) && (cfg.image_height != '0);
				fin_c = !run;
			end else if (fin_q) begin
				run = 1'b0;
			end else if (odd_q && (pos_q < cfg.odd_field_start)) begin
				// byte before the odd field data: dropped
				pos_c = pos_q + 1'b1;
				run   = 1'b0;
			end else begin
				run = 1'b1;
			end
		end

		pos_inc = {1'b0, pos_c} + (OFFSET_BITS + 1)'(1);
		adv_ok  = pos_inc < {1'b0, cfg.data_length};
		fld_a   = fld_c + 1'b1;
		f_a     = fields_c[fld_c[FIELD_IDX_BITS-1:0]];
		f_b     = fields_c[fld_a[FIELD_IDX_BITS-1:0]];
		col_inc = {1'b0, col_c} + (DIM_BITS + 1)'(1);
		nr      = {1'b0, row_c} + (DIM_BITS + 1)'(2);
		row_end = col_inc >= {1'b0, cfg.image_width};
		eoi_c   = row_end && (nr >= {1'b0, cfg.image_height})
			&& (odd_c || (cfg.image_height <= DIM_BITS'(1)));

		pos_n  = pos_c;
		row_n  = row_c;
		col_n  = col_c;
		odd_n  = odd_c;
		zp_n   = zp_c;
		aw_n   = aw_c;
		fin_n  = fin_c;
		fld_n  = fld_c;
		live_n = live_c;
		perr_n = perr_c;
		color  = '0;
		pix    = 1'b0;
		is_err = 1'b0;
		done   = 1'b0;
		silent = 1'b0;

		if (run) begin
			if (perr_c) begin
				is_err = 1'b1;
			end else if (zp_c != '0) begin
				zp_n = zp_c - 1'b1;
				pix  = 1'b1;
			end else if (!live_c) begin
				done = 1'b1;
			end else if (aw_c) begin
				// count field of a run opened in the previous byte
				zp_n  = f_a;
				fld_n = fld_a;
				aw_n  = 1'b0;
				pix   = 1'b1;
			end else begin
				color = f_a;
				fld_n = fld_a;
				if (fld_c == LAST_FIELD) begin
					if (!adv_ok) begin
						is_err = 1'b1;
					end else begin
						pos_n  = pos_inc[OFFSET_BITS-1:0];
						live_n = 1'b0;
					end
				end
				if (!is_err) begin
					if (f_a == '0) begin
						if (!live_n) begin
							// count sits in the next byte
							aw_n = 1'b1;
							done = 1'b1;
						end else begin
							zp_n  = f_b;
							fld_n = fld_c + FLD_BITS'(2);
							if (fld_c == LAST_FIELD - 1'b1) begin
								if (!adv_ok) begin
									is_err = 1'b1;
								end else begin
									pos_n  = pos_inc[OFFSET_BITS-1:0];
									live_n = 1'b0;
								end
							end
							pix = !is_err;
						end
					end else begin
						pix = 1'b1;
					end
				end
			end

			if (pix) begin
				if (!row_end) begin
					col_n = col_inc[DIM_BITS-1:0];
				end else begin
					col_n = '0;
					// skip the rest of the byte at row end
					if (live_n) begin
						if (!adv_ok) begin
							perr_n = 1'b1;
						end else begin
							pos_n  = pos_inc[OFFSET_BITS-1:0];
							live_n = 1'b0;
						end
					end
					if (!perr_n) begin
						if (eoi_c) begin
							fin_n = 1'b1;
							zp_n  = '0;
							done  = 1'b1;
						end else if (nr >= {1'b0, cfg.image_height}) begin
							odd_n  = 1'b1;
							row_n  = DIM_BITS'(1);
							live_n = 1'b0;
						end else begin
							row_n = nr[DIM_BITS-1:0];
						end
					end
				end
				// look one step ahead to mark the last pixel of the byte
				if (!done && !perr_n) begin
					if ((zp_n == '0) && !live_n) begin
						done = 1'b1;
					end else if ((zp_n == '0) && !aw_n && (fld_n == LAST_FIELD)
							&& (fields_c[FIELDS_PER_BYTE-1] == '0) && adv_ok) begin
						silent = 1'b1;
					end
				end
			end

			if (is_err) begin
				fin_n  = 1'b1;
				zp_n   = '0;
				aw_n   = 1'b0;
				perr_n = 1'b0;
				done   = 1'b1;
			end
		end

		emit   = pix || is_err;
		busy_n = run && !done;

		out_n.pixel_index  = is_err ? '0 : color;
		out_n.pixel_row    = is_err ? '0 : row_c;
		out_n.pixel_column = is_err ? '0 : col_c;
		out_n.end_of_image = !is_err && eoi_c;
		out_n.decode_error = is_err;
		out_n.last_of_item = is_err || done || silent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			perr_q      <= 1'b0;
			live_q      <= 1'b0;
			fld_q       <= '0;
			pos_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			odd_q       <= 1'b0;
			zp_q        <= '0;
			aw_q        <= 1'b0;
			fin_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				busy_q <= busy_n;
				perr_q <= perr_n;
				live_q <= live_n;
				fld_q  <= fld_n;
				pos_q  <= pos_n;
				row_q  <= row_n;
				col_q  <= col_n;
				odd_q  <= odd_n;
				zp_q   <= zp_n;
				aw_q   <= aw_n;
				fin_q  <= fin_n;
			end
			if (ready_adv) out_valid_q <= go && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (go && start) fields_q <= q_entry.fields;
		if (ready_adv) out_q <= out_n;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`ISRD_ASSERT_IMPLY(a_err_is_last, out_valid_q && out_q.decode_error, out_q.last_of_item, "error result not last of its byte")
	`ISRD_ASSERT_IMPLY(a_err_blank, out_valid_q && out_q.decode_error, (out_q.pixel_index == '0) && !out_q.end_of_image && (out_q.pixel_row == '0) && (out_q.pixel_column == '0), "error result carries pixel data")
	`ISRD_ASSERT_IMPLY(a_busy_has_work, busy_q, (zp_q != '0) || live_q || perr_q, "sequencer busy with nothing left to do")
	`ISRD_ASSERT_IMPLY(a_fld_range, busy_q, fld_q <= FLD_BITS'(FIELDS_PER_BYTE), "field counter past end of byte")
	`ISRD_ASSERT_NEXT(a_perr_flush, busy_q && perr_q && !out_valid_q, out_valid_q && out_q.decode_error, "pending overrun not reported")

endmodule
